// ===== sv/address_offence_window_counter_top_assert.svh =====
`ifndef ADDRESS_OFFENCE_WINDOW_COUNTER_TOP_ASSERT_SVH
`define ADDRESS_OFFENCE_WINDOW_COUNTER_TOP_ASSERT_SVH

// Checks that a condition in one cycle brings a consequence in the same cycle.
`define AOWC_ASSERT_SAME(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed in address offence window counter");

// Checks that a condition in one cycle brings a consequence in the next cycle.
`define AOWC_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed in address offence window counter");

`endif

// ===== sv/aowc_pkg.sv =====
package aowc_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SECONDS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIT_THRESHOLD  = 4'd1;

   localparam logic [31:0] WINDOW_RESET    = 32'd900;
   localparam logic [15:0] THRESHOLD_RESET = 16'd3;
   localparam logic [15:0] HITS_MAX        = 16'hFFFF;
   localparam logic [15:0] HITS_ONE        = 16'd1;

   typedef struct packed {
      logic [63:0] address_upper;
      logic [63:0] address_lower;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [15:0] hit_count;
      logic        block_request;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic [63:0] address_upper;
      logic [63:0] address_lower;
      logic [15:0] hits;
      logic [31:0] last_time;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic write;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic match;
      logic rsp_free;
   } status_type;

endpackage

// ===== sv/aowc_ram.sv =====
module aowc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/aowc_ctrl.sv =====
module aowc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aowc_pkg::status_type status,
   output aowc_pkg::cmd_type    cmd
);

   aowc_pkg::state_type state_ff;
   aowc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aowc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         aowc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = aowc_pkg::ST_SCAN;
            end
         end
         aowc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.match || status.scan_done) begin
               state_in = aowc_pkg::ST_WRITE;
            end
         end
         aowc_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = aowc_pkg::ST_DONE;
         end
         aowc_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = aowc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aowc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/aowc_datapath.sv =====
module aowc_datapath #(
   parameter int TABLE_ENTRIES = aowc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  aowc_pkg::cmd_type                  cmd,
   output aowc_pkg::status_type               status,
   input  aowc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output aowc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   input  logic [aowc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [aowc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = $bits(aowc_pkg::entry_type);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [31:0]        window_ff;
   logic [15:0]        threshold_ff;
   aowc_pkg::req_type  key_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic [CNT_W-1:0]   ptr_in;
   logic               rd_vld_ff;
   logic               rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [15:0]        old_hits_ff;
   logic [31:0]        old_time_ff;
   aowc_pkg::rsp_type  res_ff;
   aowc_pkg::rsp_type  res_in;
   aowc_pkg::rsp_type  rsp_ff;
   logic               rsp_valid_ff;

   aowc_pkg::entry_type rd_entry;
   aowc_pkg::entry_type wr_entry;
   logic [ENTRY_W-1:0]  rd_word;
   logic                match_now;
   logic                issue;
   logic                full;
   logic                expired;
   logic [32:0]         limit;
   logic [15:0]         hits_new;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;

   aowc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(ptr_ff[IDX_W-1:0]),
      .rd_data(rd_word)
   );

   assign rd_entry  = aowc_pkg::entry_type'(rd_word);
   assign match_now = rd_vld_ff
                      && (rd_entry.address_upper == key_ff.address_upper)
                      && (rd_entry.address_lower == key_ff.address_lower);
   assign issue     = cmd.scan && (ptr_ff < fill_ff) && !match_now;
   assign ptr_in    = cmd.start ? '0 : (issue ? ptr_ff + CNT_ONE : ptr_ff);
   assign rd_vld_in = issue;

   assign limit   = {1'b0, old_time_ff} + {1'b0, window_ff};
   assign expired = limit < {1'b0, key_ff.now_seconds};
   assign full    = !hit_ff && (fill_ff == CNT_FULL);

   always_comb begin
      if (!hit_ff || expired) begin
         hits_new = aowc_pkg::HITS_ONE;
      end else if (old_hits_ff == aowc_pkg::HITS_MAX) begin
         hits_new = old_hits_ff;
      end else begin
         hits_new = old_hits_ff + aowc_pkg::HITS_ONE;
      end
   end

   assign res_in.hit_count     = hits_new;
   assign res_in.block_request = hits_new >= threshold_ff;
   assign res_in.table_full    = full;

   assign wr_en   = cmd.write && !full;
   assign wr_addr = hit_ff ? hit_idx_ff : fill_ff[IDX_W-1:0];
   assign wr_entry.address_upper = key_ff.address_upper;
   assign wr_entry.address_lower = key_ff.address_lower;
   assign wr_entry.hits          = hits_new;
   assign wr_entry.last_time     = key_ff.now_seconds;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= aowc_pkg::WINDOW_RESET;
         threshold_ff <= aowc_pkg::THRESHOLD_RESET;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               aowc_pkg::CSR_WINDOW_SECONDS: window_ff    <= csr_data;
               aowc_pkg::CSR_HIT_THRESHOLD:  threshold_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_vld_in;
         if (cmd.start) begin
            hit_ff <= 1'b0;
         end else if (cmd.scan && match_now) begin
            hit_ff <= 1'b1;
         end
         if (cmd.write && !hit_ff && !full) begin
            fill_ff <= fill_ff + CNT_ONE;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_data;
      end
      if (issue) begin
         rd_idx_ff <= ptr_ff[IDX_W-1:0];
      end
      if (cmd.scan && match_now) begin
         hit_idx_ff  <= rd_idx_ff;
         old_hits_ff <= rd_entry.hits;
         old_time_ff <= rd_entry.last_time;
      end
      if (cmd.write) begin
         res_ff <= res_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign status.scan_done = !rd_vld_ff && (ptr_ff >= fill_ff);
   assign status.match     = match_now;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/address_offence_window_counter_top.sv =====
// Counts offence events per 128-bit address in a table of TABLE_ENTRIES entries held in one
// RAM. Each event is looked up by a scan of the filled part of the table through the RAM's
// single read port, one entry per cycle, and the scan stops early when the address is found.
// Entries fill from the bottom and are never freed, so a fill count replaces valid bits and no
// clearing pass follows reset. The result waits in an output register, and configuration writes
// are always ready and must only be made while no event is in flight.
`include "address_offence_window_counter_top_assert.svh"

module address_offence_window_counter_top #(
   parameter int TABLE_ENTRIES = aowc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  aowc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output aowc_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [aowc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [aowc_pkg::CSR_DATA_W-1:0]  csr_data
);

   aowc_pkg::cmd_type    cmd;
   aowc_pkg::status_type status;

   assign csr_ready = 1'b1;

   aowc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   aowc_datapath #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // A new transaction is not taken while the previous one is still being looked up.
   `AOWC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // A finished result always shows up on the response channel.
   `AOWC_ASSERT_NEXT(a_rsp_after_load, clock, reset, cmd.load_rsp, rsp_valid)
   // The result is only loaded when the output register can take it.
   `AOWC_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_rsp, !rsp_valid || !rsp_stall)

endmodule
